>>> hw/rtl/mktd_pkg.sv
`default_nettype none

package mktd_pkg;

  // Depth of the original key buffer; the symbol store keeps one slot less.
  localparam int unsigned BufferSize = 8;
  localparam int unsigned StoreBits  = 7;
  localparam int unsigned StoreCapInt =
      ((BufferSize - 1) > StoreBits) ? StoreBits : (BufferSize - 1);
  localparam logic [2:0] StoreCap = StoreCapInt[2:0];

  localparam int unsigned TimeW = 32;
  localparam int unsigned GapW  = 16;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LETTER = 2'd1,
    EV_WORD   = 2'd2
  } event_kind_e;

  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_RESET  = 1'b1
  } req_type_e;

  // Register indexes, byte address is 4 * index.
  localparam logic [1:0] RegDashThreshold = 2'd0;
  localparam logic [1:0] RegLetterGap     = 2'd1;
  localparam logic [1:0] RegWordGap       = 2'd2;

  localparam logic [GapW-1:0] DashThresholdReset = 16'd250;
  localparam logic [GapW-1:0] LetterGapReset     = 16'd700;
  localparam logic [GapW-1:0] WordGapReset       = 16'd1500;

endpackage

`default_nettype wire

>>> hw/rtl/mktd_if.sv
`default_nettype none

interface mktd_key_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic                         key_down;
  logic [mktd_pkg::TimeW-1:0]   time_ms;

  modport source (output valid, req_type, key_down, time_ms, input ready);
  modport sink   (input valid, req_type, key_down, time_ms, output ready);
endinterface

interface mktd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [6:0] letter_symbols;
  logic [2:0] letter_length;

  modport source (output valid, event_kind, letter_symbols, letter_length, input ready);
  modport sink   (input valid, event_kind, letter_symbols, letter_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/morse_key_timing_decoder.sv
// An item passes the input register, then the result register. Throughput: one item per
// cycle without backpressure; the state update is one subtract-and-compare pass per item.
// Backpressure: a stalled result register lets the input register take one more item, then
// input ready drops until the result is taken.
// Reset: rst_ni clears key state, symbol store and the word-gap flag, and loads the
// registers with 250 / 700 / 1500 ms. A soft reset item keeps the word-gap flag.
`default_nettype none

module morse_key_timing_decoder (
  input  wire          clk_i,
  input  wire          rst_ni,
  // configuration port
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // item channels
  mktd_key_if.sink     item_i,
  mktd_event_if.source result_o
);

  localparam int unsigned TW = mktd_pkg::TimeW;
  localparam int unsigned GW = mktd_pkg::GapW;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [GW-1:0] dash_thr_q, letter_gap_q, word_gap_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_thr_q   <= mktd_pkg::DashThresholdReset;
      letter_gap_q <= mktd_pkg::LetterGapReset;
      word_gap_q   <= mktd_pkg::WordGapReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mktd_pkg::RegDashThreshold: dash_thr_q   <= pwdata[GW-1:0];
        mktd_pkg::RegLetterGap:     letter_gap_q <= pwdata[GW-1:0];
        mktd_pkg::RegWordGap:       word_gap_q   <= pwdata[GW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mktd_pkg::RegDashThreshold: prdata = {16'd0, dash_thr_q};
      mktd_pkg::RegLetterGap:     prdata = {16'd0, letter_gap_q};
      mktd_pkg::RegWordGap:       prdata = {16'd0, word_gap_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input register. The stage advances whenever the result register is
  // empty or being drained, so a stalled result holds at most one item
  // here and one in the result register.
  // ------------------------------------------------------------------
  logic          stg_valid_q;
  logic          stg_req_q;
  logic          stg_down_q;
  logic [TW-1:0] stg_time_q;
  logic          advance;
  logic          in_acc;

  assign advance      = !result_o.valid || result_o.ready;
  assign item_i.ready = !stg_valid_q || advance;
  assign in_acc       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      stg_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_req_q  <= item_i.req_type;
      stg_down_q <= item_i.key_down;
      stg_time_q <= item_i.time_ms;
    end
  end

  // ------------------------------------------------------------------
  // Decoder state
  // ------------------------------------------------------------------
  logic          key_held_q,  key_held_d;
  logic [TW-1:0] press_q,     press_d;
  logic [TW-1:0] release_q,   release_d;
  logic          gap_rep_q,   gap_rep_d;
  logic [6:0]    store_q,     store_d;
  logic [2:0]    count_q,     count_d;

  mktd_pkg::event_kind_e kind_d;
  logic [6:0]            syms_d;
  logic [2:0]            len_d;

  logic                  do_step;
  logic [TW-1:0]         press_len;
  logic [TW-1:0]         idle_len;

  assign do_step = stg_valid_q && advance;

  always_comb begin
    key_held_d = key_held_q;
    press_d    = press_q;
    release_d  = release_q;
    gap_rep_d  = gap_rep_q;
    store_d    = store_q;
    count_d    = count_q;
    kind_d     = mktd_pkg::EV_NONE;
    syms_d     = 7'd0;
    len_d      = 3'd0;
    press_len  = stg_time_q - press_q;
    idle_len   = '0;

    if (stg_req_q == mktd_pkg::REQ_RESET) begin
      // Soft reset: clear all but the word-gap flag.
      key_held_d = 1'b0;
      press_d    = '0;
      release_d  = '0;
      store_d    = 7'd0;
      count_d    = 3'd0;
    end else begin
      // Press edge: remember when it started.
      if (stg_down_q && !key_held_q) begin
        key_held_d = 1'b1;
        press_d    = stg_time_q;
      end
      // Release edge: append dot or dash unless the store is full.
      if (!stg_down_q && key_held_q) begin
        key_held_d = 1'b0;
        if (count_q < mktd_pkg::StoreCap) begin
          if (press_len >= {{(TW-GW){1'b0}}, dash_thr_q}) begin
            store_d[count_q] = 1'b1;
          end
          count_d   = count_q + 3'd1;
          release_d = stg_time_q;
          gap_rep_d = 1'b0;
        end
      end
      idle_len = stg_time_q - release_d;
      // Letter gap: emit and clear the store.
      if (!stg_down_q && !key_held_d && (count_d != 3'd0) &&
          (idle_len >= {{(TW-GW){1'b0}}, letter_gap_q})) begin
        kind_d  = mktd_pkg::EV_LETTER;
        syms_d  = store_d;
        len_d   = count_d;
        store_d = 7'd0;
        count_d = 3'd0;
      end
      // Word gap comes last and overrides a letter in the same step.
      if (!stg_down_q && !key_held_d && (count_d == 3'd0) && !gap_rep_d &&
          (idle_len >= {{(TW-GW){1'b0}}, word_gap_q})) begin
        gap_rep_d = 1'b1;
        kind_d    = mktd_pkg::EV_WORD;
        syms_d    = 7'd0;
        len_d     = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_held_q <= 1'b0;
      press_q    <= '0;
      release_q  <= '0;
      gap_rep_q  <= 1'b0;
      store_q    <= 7'd0;
      count_q    <= 3'd0;
    end else if (do_step) begin
      key_held_q <= key_held_d;
      press_q    <= press_d;
      release_q  <= release_d;
      gap_rep_q  <= gap_rep_d;
      store_q    <= store_d;
      count_q    <= count_d;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  logic       res_valid_q;
  logic [1:0] res_kind_q;
  logic [6:0] res_syms_q;
  logic [2:0] res_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= stg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      res_kind_q <= kind_d;
      res_syms_q <= syms_d;
      res_len_q  <= len_d;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.event_kind     = res_kind_q;
  assign result_o.letter_symbols = res_syms_q;
  assign result_o.letter_length  = res_len_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mktd_pkg::StoreCap)
    else $error("symbol count above store capacity");

  a_letter_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.event_kind == mktd_pkg::EV_LETTER)
      |-> (result_o.letter_length != 3'd0))
    else $error("letter event with no symbols");

  a_nonletter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.event_kind != mktd_pkg::EV_LETTER)
      |-> (result_o.letter_symbols == 7'd0) && (result_o.letter_length == 3'd0))
    else $error("letter fields set outside a letter event");

  a_soft_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step && (stg_req_q == mktd_pkg::REQ_RESET)
      |=> (count_q == 3'd0) && !key_held_q && (store_q == 7'd0))
    else $error("soft reset left decoder state");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && !advance |=> stg_valid_q && $stable(stg_time_q))
    else $error("input register lost an item under backpressure");

  a_word_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step && (kind_d == mktd_pkg::EV_WORD) |=> gap_rep_q && (count_q == 3'd0))
    else $error("word gap without flag set and store empty");

endmodule

`default_nettype wire
